@@ rtl/core/lrsgd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsgd_pkg
// shared types, constants and helpers for the sgd linear regression trainer
// ----------------------------------------------------------------------------
package lrsgd_pkg;

    localparam int DATA_W        = 32;
    localparam int ERR_W         = 31;
    localparam int RATE_W        = 16;
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd655;
    localparam logic [DATA_W-1:0] ERR_RESET  = 32'hFFFF_FFFF;
    localparam logic [ERR_W-1:0]  ERR_MAX    = 31'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] DATA_MIN   = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIT_MUL,
        ST_FIT_SUM,
        ST_FIT_DEV,
        ST_FIT_RATE,
        ST_FIT_STEP0,
        ST_FIT_GAIN,
        ST_FIT_STEP1,
        ST_FIT_BEST,
        ST_PRED_MUL,
        ST_PRED_SUM
    } state_t;

    typedef enum logic [1:0] {
        MUL_SLOPE_X,
        MUL_RATE_D,
        MUL_STEP_X,
        MUL_BEST_X
    } mul_sel_t;

    typedef struct packed {
        logic     s_ready;
        logic     load_in;
        mul_sel_t mul_sel;
        logic     sum_en;
        logic     dev_en;
        logic     step0_en;
        logic     step1_en;
        logic     best_en;
        logic     out_load;
    } ctrl_t;

    // saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > hi) begin
            sat32 = hi[DATA_W-1:0];
        end else if (v < lo) begin
            sat32 = lo[DATA_W-1:0];
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

@@ rtl/core/lrsgd_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsgd_mult
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module lrsgd_mult (
    input  logic                                 aclk,
    input  logic signed [lrsgd_pkg::MUL_W-1:0]   op_a,
    input  logic signed [lrsgd_pkg::MUL_W-1:0]   op_b,
    output logic signed [lrsgd_pkg::PROD_W-1:0]  prod
);

    logic signed [2*lrsgd_pkg::MUL_W-1:0] full_prod;
    logic signed [lrsgd_pkg::PROD_W-1:0]  prod_reg;

    assign full_prod = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= full_prod[lrsgd_pkg::PROD_W-1:0];
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/lrsgd_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsgd_seq
// sequencer stepping one transaction through the shared multiplier
// ----------------------------------------------------------------------------
module lrsgd_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_action,
    input  logic              out_free,
    output lrsgd_pkg::ctrl_t  ctrl
);

    lrsgd_pkg::state_t state_reg;
    lrsgd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrsgd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lrsgd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_action ? lrsgd_pkg::ST_PRED_MUL : lrsgd_pkg::ST_FIT_MUL;
                end
            end
            lrsgd_pkg::ST_FIT_MUL:   state_next = lrsgd_pkg::ST_FIT_SUM;
            lrsgd_pkg::ST_FIT_SUM:   state_next = lrsgd_pkg::ST_FIT_DEV;
            lrsgd_pkg::ST_FIT_DEV:   state_next = lrsgd_pkg::ST_FIT_RATE;
            lrsgd_pkg::ST_FIT_RATE:  state_next = lrsgd_pkg::ST_FIT_STEP0;
            lrsgd_pkg::ST_FIT_STEP0: state_next = lrsgd_pkg::ST_FIT_GAIN;
            lrsgd_pkg::ST_FIT_GAIN:  state_next = lrsgd_pkg::ST_FIT_STEP1;
            lrsgd_pkg::ST_FIT_STEP1: state_next = lrsgd_pkg::ST_FIT_BEST;
            lrsgd_pkg::ST_FIT_BEST:  state_next = lrsgd_pkg::ST_PRED_MUL;
            lrsgd_pkg::ST_PRED_MUL:  state_next = lrsgd_pkg::ST_PRED_SUM;
            lrsgd_pkg::ST_PRED_SUM: begin
                if (out_free) begin
                    state_next = lrsgd_pkg::ST_IDLE;
                end
            end
            default: state_next = lrsgd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl          = '0;
        ctrl.mul_sel  = lrsgd_pkg::MUL_SLOPE_X;
        unique case (state_reg)
            lrsgd_pkg::ST_IDLE: begin
                ctrl.s_ready = 1'b1;
                ctrl.load_in = s_valid;
            end
            lrsgd_pkg::ST_FIT_MUL:   ctrl.mul_sel = lrsgd_pkg::MUL_SLOPE_X;
            lrsgd_pkg::ST_FIT_SUM:   ctrl.sum_en = 1'b1;
            lrsgd_pkg::ST_FIT_DEV:   ctrl.dev_en = 1'b1;
            lrsgd_pkg::ST_FIT_RATE:  ctrl.mul_sel = lrsgd_pkg::MUL_RATE_D;
            lrsgd_pkg::ST_FIT_STEP0: ctrl.step0_en = 1'b1;
            lrsgd_pkg::ST_FIT_GAIN:  ctrl.mul_sel = lrsgd_pkg::MUL_STEP_X;
            lrsgd_pkg::ST_FIT_STEP1: ctrl.step1_en = 1'b1;
            lrsgd_pkg::ST_FIT_BEST:  ctrl.best_en = 1'b1;
            lrsgd_pkg::ST_PRED_MUL:  ctrl.mul_sel = lrsgd_pkg::MUL_BEST_X;
            lrsgd_pkg::ST_PRED_SUM: begin
                ctrl.mul_sel  = lrsgd_pkg::MUL_BEST_X;
                ctrl.out_load = out_free;
            end
            default: ctrl = '0;
        endcase
    end

endmodule

@@ rtl/core/linear_regression_sgd_trainer_core.sv @@
`timescale 1ns / 1ps
// a new transaction is accepted only in idle, after the previous one has loaded its result;
// train and predict transactions run as a sequence of dependent products through the
// single shared 33x33 multiplier
// the result register frees the core once the result is loaded
// reset: synchronous active-low aresetn zeroes coefficients and best pair, sets the
// least error to all ones and the rate to its default
// ----------------------------------------------------------------------------
// linear_regression_sgd_trainer_core
// online linear regression by stochastic gradient descent, signed fixed point
// ----------------------------------------------------------------------------
module linear_regression_sgd_trainer_core #(
    parameter int FRAC_BITS = lrsgd_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrsgd_pkg::RATE_W-1:0]        cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic signed [lrsgd_pkg::DATA_W-1:0] s_x_value,
    input  logic signed [lrsgd_pkg::DATA_W-1:0] s_y_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lrsgd_pkg::DATA_W-1:0] m_intercept,
    output logic signed [lrsgd_pkg::DATA_W-1:0] m_slope,
    output logic [lrsgd_pkg::ERR_W-1:0]         m_abs_error,
    output logic [lrsgd_pkg::ERR_W-1:0]         m_best_error,
    output logic signed [lrsgd_pkg::DATA_W-1:0] m_prediction
);

    localparam int DW = lrsgd_pkg::DATA_W;
    localparam int PW = lrsgd_pkg::PROD_W;
    localparam int MW = lrsgd_pkg::MUL_W;
    localparam int RW = lrsgd_pkg::RATE_W;
    localparam int EW = lrsgd_pkg::ERR_W;

    lrsgd_pkg::ctrl_t ctrl;

    logic [RW-1:0]        rate_reg;
    logic signed [DW-1:0] x_reg;
    logic signed [DW-1:0] y_reg;
    logic signed [DW-1:0] b0_reg;
    logic signed [DW-1:0] b1_reg;
    logic signed [DW-1:0] bb0_reg;
    logic signed [DW-1:0] bb1_reg;
    logic [DW-1:0]        least_reg;
    logic signed [DW-1:0] p_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] s0_reg;
    logic [EW-1:0]        absd_reg;

    logic                 m_valid_reg;
    logic signed [DW-1:0] m_intercept_reg;
    logic signed [DW-1:0] m_slope_reg;
    logic [EW-1:0]        m_abs_error_reg;
    logic [EW-1:0]        m_best_error_reg;
    logic signed [DW-1:0] m_prediction_reg;

    logic signed [MW-1:0] op_a;
    logic signed [MW-1:0] op_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_frac;
    logic signed [DW-1:0] s0_w;
    logic signed [PW-1:0] dev_full;
    logic signed [DW-1:0] d_neg;
    logic [EW-1:0]        absd_w;
    logic                 out_free;

    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign s_ready   = ctrl.s_ready;

    lrsgd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // multiplier operand select
    always_comb begin
        case (ctrl.mul_sel)
            lrsgd_pkg::MUL_SLOPE_X: begin
                op_a = MW'(b1_reg);
                op_b = MW'(x_reg);
            end
            lrsgd_pkg::MUL_RATE_D: begin
                op_a = signed'({{(MW-RW){1'b0}}, rate_reg});
                op_b = MW'(d_reg);
            end
            lrsgd_pkg::MUL_STEP_X: begin
                op_a = MW'(s0_reg);
                op_b = MW'(x_reg);
            end
            lrsgd_pkg::MUL_BEST_X: begin
                op_a = MW'(bb1_reg);
                op_b = MW'(x_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    lrsgd_mult u_mult (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign prod_frac = prod >>> FRAC_BITS;
    assign s0_w      = prod[RW+DW-1:RW];
    assign dev_full  = PW'(p_reg) - PW'(y_reg);
    assign d_neg     = -d_reg;

    // magnitude of the deviation, most negative value clamps
    always_comb begin
        if (!d_reg[DW-1]) begin
            absd_w = d_reg[EW-1:0];
        end else if (d_reg == lrsgd_pkg::DATA_MIN) begin
            absd_w = lrsgd_pkg::ERR_MAX;
        end else begin
            absd_w = d_neg[EW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= lrsgd_pkg::RATE_RESET;
            b0_reg    <= '0;
            b1_reg    <= '0;
            bb0_reg   <= '0;
            bb1_reg   <= '0;
            least_reg <= lrsgd_pkg::ERR_RESET;
        end else begin
            if (cfg_valid) begin
                rate_reg <= cfg_data;
            end
            if (ctrl.step0_en) begin
                b0_reg <= lrsgd_pkg::sat32(PW'(b0_reg) - PW'(s0_w));
            end
            if (ctrl.step1_en) begin
                b1_reg <= lrsgd_pkg::sat32(PW'(b1_reg) - prod_frac);
            end
            if (ctrl.best_en && ({1'b0, absd_reg} < least_reg)) begin
                least_reg <= {1'b0, absd_reg};
                bb0_reg   <= b0_reg;
                bb1_reg   <= b1_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (ctrl.load_in) begin
            x_reg    <= s_x_value;
            y_reg    <= s_y_value;
            absd_reg <= '0;
        end
        if (ctrl.sum_en) begin
            p_reg <= lrsgd_pkg::sat32(PW'(b0_reg) + prod_frac);
        end
        if (ctrl.dev_en) begin
            d_reg <= lrsgd_pkg::sat32(dev_full);
        end
        if (ctrl.step0_en) begin
            s0_reg   <= s0_w;
            absd_reg <= absd_w;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_intercept_reg  <= b0_reg;
            m_slope_reg      <= b1_reg;
            m_abs_error_reg  <= absd_reg;
            m_best_error_reg <= least_reg[DW-1] ? lrsgd_pkg::ERR_MAX : least_reg[EW-1:0];
            m_prediction_reg <= lrsgd_pkg::sat32(PW'(bb0_reg) + prod_frac);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_intercept  = m_intercept_reg;
    assign m_slope      = m_slope_reg;
    assign m_abs_error  = m_abs_error_reg;
    assign m_best_error = m_best_error_reg;
    assign m_prediction = m_prediction_reg;

endmodule

@@ dv/tb_linear_regression_sgd_trainer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_regression_sgd_trainer_core
// self-checking bench for the sgd linear regression trainer, queued clocked
// driver, fixed-point predictor and in-order monitor, learn rate rewritten
// between segments, random sender and receiver idling
// ----------------------------------------------------------------------------
module tb_linear_regression_sgd_trainer_core;

    localparam int FRAC          = lrsgd_pkg::FRAC_BITS_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_SEGS      = 6;

    localparam logic ACT_TRAIN   = 1'b0;
    localparam logic ACT_PREDICT = 1'b1;

    localparam logic [lrsgd_pkg::DATA_W-1:0] X_MAX = 32'h7FFF_FFFF;
    localparam logic [lrsgd_pkg::DATA_W-1:0] X_MIN = 32'h8000_0000;
    localparam logic [lrsgd_pkg::DATA_W-1:0] ONE_Q = 32'h0001_0000;

    localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic                         action;
        logic [lrsgd_pkg::DATA_W-1:0] x;
        logic [lrsgd_pkg::DATA_W-1:0] y;
    } sample_t;

    typedef struct packed {
        logic [lrsgd_pkg::DATA_W-1:0] intercept;
        logic [lrsgd_pkg::DATA_W-1:0] slope;
        logic [lrsgd_pkg::ERR_W-1:0]  abs_error;
        logic [lrsgd_pkg::ERR_W-1:0]  best_error;
        logic [lrsgd_pkg::DATA_W-1:0] prediction;
    } fit_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [lrsgd_pkg::RATE_W-1:0] cfg_data  = '0;

    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    logic                                s_action  = ACT_TRAIN;
    logic signed [lrsgd_pkg::DATA_W-1:0] s_x_value = '0;
    logic signed [lrsgd_pkg::DATA_W-1:0] s_y_value = '0;

    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [lrsgd_pkg::DATA_W-1:0] m_intercept;
    logic signed [lrsgd_pkg::DATA_W-1:0] m_slope;
    logic [lrsgd_pkg::ERR_W-1:0]         m_abs_error;
    logic [lrsgd_pkg::ERR_W-1:0]         m_best_error;
    logic signed [lrsgd_pkg::DATA_W-1:0] m_prediction;

    // model state
    logic signed [63:0]           cur_b0;
    logic signed [63:0]           cur_b1;
    logic signed [63:0]           best_b0;
    logic signed [63:0]           best_b1;
    logic [31:0]                  least_err;
    logic [lrsgd_pkg::RATE_W-1:0] rate_q;

    sample_t     pending_samples[$];
    fit_result_t expected_fits[$];
    sample_t     next_sample;
    fit_result_t want_fit;
    fit_result_t got_fit;

    int send_idle_pct = 33;
    int recv_idle_pct = 62;
    int recv_hold     = 0;
    int idle_run      = 0;
    int mismatches    = 0;
    int trained_cnt   = 0;
    int predicted_cnt = 0;
    int checked_cnt   = 0;
    int best_updates  = 0;
    int rate_settings = 0;

    int          seg_items[NUM_SEGS] = '{400, 150, 350, 150, 100, 850};
    int          seg_send [NUM_SEGS] = '{33, 33, 62, 62, 0, 0};
    int          seg_recv [NUM_SEGS] = '{62, 62, 33, 33, 0, 0};
    logic [15:0] seg_rate [NUM_SEGS];

    linear_regression_sgd_trainer_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_x_value    (s_x_value),
        .s_y_value    (s_y_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_intercept  (m_intercept),
        .m_slope      (m_slope),
        .m_abs_error  (m_abs_error),
        .m_best_error (m_best_error),
        .m_prediction (m_prediction)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
        if (v > Q_MAX) begin
            return Q_MAX;
        end else if (v < Q_MIN) begin
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] line_at(input logic signed [63:0] b0,
                                                   input logic signed [63:0] b1,
                                                   input logic signed [63:0] x);
        return clamp_q(b0 + ((b1 * x) >>> FRAC));
    endfunction

    // one sgd step or prediction, a step updates the model state
    function automatic fit_result_t sgd_fit_step(input sample_t smp);
        logic signed [63:0] xw;
        logic signed [63:0] yw;
        logic signed [63:0] rate_w;
        logic signed [63:0] dev;
        logic signed [63:0] step0;
        logic signed [63:0] step1;
        logic signed [63:0] mag;
        logic signed [63:0] pred;
        logic [31:0]        absd;
        fit_result_t        res;
        xw     = {{32{smp.x[31]}}, smp.x};
        yw     = {{32{smp.y[31]}}, smp.y};
        rate_w = {{(64-lrsgd_pkg::RATE_W){1'b0}}, rate_q};
        absd   = '0;
        if (smp.action == ACT_TRAIN) begin
            dev   = clamp_q(line_at(cur_b0, cur_b1, xw) - yw);
            step0 = (rate_w * dev) >>> lrsgd_pkg::RATE_W;
            step1 = (step0 * xw) >>> FRAC;
            mag   = (dev < 0) ? -dev : dev;
            if (mag > Q_MAX) begin
                mag = Q_MAX;
            end
            absd   = mag[31:0];
            cur_b0 = clamp_q(cur_b0 - step0);
            cur_b1 = clamp_q(cur_b1 - step1);
            if (absd < least_err) begin
                least_err = absd;
                best_b0   = cur_b0;
                best_b1   = cur_b1;
                best_updates++;
            end
        end
        pred           = line_at(best_b0, best_b1, xw);
        res.intercept  = cur_b0[31:0];
        res.slope      = cur_b1[31:0];
        res.abs_error  = absd[30:0];
        res.best_error = (least_err > {1'b0, lrsgd_pkg::ERR_MAX}) ? lrsgd_pkg::ERR_MAX
                                                                    : least_err[30:0];
        res.prediction = pred[31:0];
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                next_sample = '{action: s_action, x: s_x_value, y: s_y_value};
                expected_fits.insert(expected_fits.size(), sgd_fit_step(next_sample));
                if (s_action == ACT_TRAIN) begin
                    trained_cnt++;
                end else begin
                    predicted_cnt++;
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    next_sample = pending_samples.pop_front();
                    s_valid   <= 1'b1;
                    s_action  <= next_sample.action;
                    s_x_value <= next_sample.x;
                    s_y_value <= next_sample.y;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_fit = '{m_intercept, m_slope, m_abs_error, m_best_error, m_prediction};
                checked_cnt++;
                if (expected_fits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] unexpected result transaction", $realtime);
                    end
                end else begin
                    want_fit = expected_fits.pop_front();
                    if (got_fit !== want_fit) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("[%0t] mismatch on result %0d", $realtime, checked_cnt);
                            $display("  intercept  exp %h got %h",
                                     want_fit.intercept, got_fit.intercept);
                            $display("  slope      exp %h got %h",
                                     want_fit.slope, got_fit.slope);
                            $display("  abs_error  exp %h got %h",
                                     want_fit.abs_error, got_fit.abs_error);
                            $display("  best_error exp %h got %h",
                                     want_fit.best_error, got_fit.best_error);
                            $display("  prediction exp %h got %h",
                                     want_fit.prediction, got_fit.prediction);
                        end
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_run);
                $display("tb_linear_regression_sgd_trainer_core NOT OK");
                $finish;
            end
        end
    end

    task automatic push_sample(input logic act, input logic [31:0] x, input logic [31:0] y);
        sample_t smp;
        smp = '{action: act, x: x, y: y};
        pending_samples.insert(pending_samples.size(), smp);
    endtask

    // mostly noisy points on a random line, some predicts and raw noise
    task automatic push_random(input int b0, input int b1);
        int    pick;
        int    xi;
        int    noise;
        longint yl;
        pick = $urandom_range(99);
        if (pick < 8) begin
            push_sample(1'($urandom_range(1)), $urandom, $urandom);
        end else if (pick < 22) begin
            xi = int'($urandom_range(1048576)) - 524288;
            push_sample(ACT_PREDICT, (pick < 12) ? $urandom : xi, $urandom);
        end else begin
            xi    = int'($urandom_range(1048576)) - 524288;
            noise = int'($urandom_range(8192)) - 4096;
            yl    = longint'(b0) + ((longint'(b1) * longint'(xi)) >>> FRAC) + noise;
            push_sample(ACT_TRAIN, xi, yl[31:0]);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        while (pending_samples.size() != 0 || s_valid || expected_fits.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_rate(input logic [lrsgd_pkg::RATE_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_q = v;
        rate_settings++;
        @(negedge aclk);
    endtask

    initial begin
        int b0;
        int b1;
        cur_b0    = '0;
        cur_b1    = '0;
        best_b0   = '0;
        best_b1   = '0;
        least_err = '1;
        rate_q    = lrsgd_pkg::RATE_RESET;
        seg_rate  = '{16'd655, 16'd0, 16'd0, 16'd1, 16'hFFFF, 16'd4000};
        seg_rate[2] = 16'($urandom_range(65535));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: no training yet, saturated deviations, tie, extremes
        write_rate(16'hFFFF);
        push_sample(ACT_PREDICT, X_MAX, X_MIN);
        push_sample(ACT_PREDICT, X_MIN, X_MAX);
        push_sample(ACT_TRAIN, 32'd0, X_MIN);
        push_sample(ACT_TRAIN, 32'd0, X_MAX);
        push_sample(ACT_PREDICT, ONE_Q, 32'd0);
        push_sample(ACT_TRAIN, X_MAX, X_MAX);
        push_sample(ACT_TRAIN, X_MIN, X_MIN);
        push_sample(ACT_TRAIN, X_MIN, X_MAX);
        push_sample(ACT_TRAIN, X_MAX, X_MIN);
        push_sample(ACT_PREDICT, X_MAX, 32'hFFFF_FFFF);
        push_sample(ACT_TRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(ACT_TRAIN, 32'd1, 32'd1);
        push_sample(ACT_PREDICT, 32'hFFFF_FFFF, 32'd0);
        for (int i = 0; i < 6; i++) begin
            push_sample(ACT_TRAIN, ONE_Q, 32'h0002_0000);
        end
        push_sample(ACT_TRAIN, 32'hFFFF_0000, 32'h0000_8000);
        push_sample(ACT_PREDICT, ONE_Q, 32'hA5A5_5A5A);
        drain();

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            write_rate(seg_rate[seg]);
            send_idle_pct = seg_send[seg];
            recv_idle_pct = seg_recv[seg];
            b0 = int'($urandom_range(524288)) - 262144;
            b1 = int'($urandom_range(524288)) - 262144;
            for (int i = 0; i < seg_items[seg]; i++) begin
                push_random(b0, b1);
            end
            if (seg == 0) begin
                // long receiver stall while the sender keeps offering
                while (pending_samples.size() > 250) @(negedge aclk);
                recv_hold = HOLD_CYCLES;
            end
            drain();
        end

        $display("covered %0d train and %0d predict transactions, %0d learn rates",
                 trained_cnt, predicted_cnt, rate_settings);
        $display("checked %0d results, %0d best-pair updates, %0d mismatches",
                 checked_cnt, best_updates, mismatches);
        if (mismatches == 0 && expected_fits.size() == 0) begin
            $display("tb_linear_regression_sgd_trainer_core OK");
        end else begin
            $display("tb_linear_regression_sgd_trainer_core NOT OK");
        end
        $finish;
    end

endmodule

@@ linear_regression_sgd_trainer_core.f @@
rtl/core/lrsgd_pkg.sv
rtl/core/lrsgd_mult.sv
rtl/core/lrsgd_seq.sv
rtl/core/linear_regression_sgd_trainer_core.sv
dv/tb_linear_regression_sgd_trainer_core.sv
